[sv/trigamma_asymptotic_top_assert.svh]
// Assertion macros for the trigamma pipeline
`ifndef TRIGAMMA_ASYMPTOTIC_TOP_ASSERT_SVH
`define TRIGAMMA_ASYMPTOTIC_TOP_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge
`define TGA_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TGA_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/tga_pkg.sv]
// Types, constants and divider step for the trigamma pipeline
`timescale 1ns / 1ps

package tga_pkg;

   localparam int LANES = 6;

   // pipeline stage map
   localparam int ST_IN     = 0;
   localparam int ST_SQR    = 1;
   localparam int ST_DIV0   = 2;
   localparam int ST_RDIVN  = 31;
   localparam int ST_W      = 32;
   localparam int ST_S      = 48;
   localparam int ST_CDIVN  = 49;
   localparam int ST_SINIT  = 49;
   localparam int ST_CSUM0  = 50;
   localparam int ST_CSUM1  = 51;
   localparam int ST_SDIV0  = 50;
   localparam int ST_SDIVN  = 80;
   localparam int ST_TOT    = 81;
   localparam int ST_OUT    = 82;
   localparam int NST       = 83;

   // fixed-point constants
   localparam logic [30:0] SIX_RAW  = 31'(6 << 16);
   localparam logic [39:0] CREM0    = 40'h00_0001_0000;
   localparam logic [39:0] DSAT_LIM = 40'h00_0001_0000;
   localparam logic [30:0] RREM0    = 31'h0004_0000;
   localparam logic [33:0] FX_ONE   = 34'h1_0000_0000;
   localparam logic [31:0] OUT_MAX  = 32'hFFFF_FFFF;

   // series coefficients B2..B16 in Q.32, rounded to nearest
   localparam logic signed [35:0] BERN_COEF [8] = '{
      36'sd715827883,   -36'sd143165577,
      36'sd102261126,   -36'sd143165577,
      36'sd325376310,   -36'sd1087114433,
      36'sd5010795179,  -36'sd30460581784
   };

   typedef struct packed {
      logic                     bad;
      logic                     shifted;
      logic [30:0]              y;
      logic [LANES-1:0][19:0]   yk;
      logic [LANES-1:0][39:0]   dk;
      logic                     dsat;
      logic [LANES-1:0][39:0]   crem;
      logic [LANES-1:0][47:0]   cq;
      logic [30:0]              rrem;
      logic [29:0]              rq;
      logic [26:0]              w;
      logic signed [35:0]       acc;
      logic                     neg;
      logic [61:0]              prod;
      logic [32:0]              su;
      logic [30:0]              srem;
      logic [30:0]              sq;
      logic [2:0][48:0]         c3;
      logic [50:0]              csum;
      logic [51:0]              total;
      logic [31:0]              value;
      logic                     sat;
   } item_type;

   // one restoring division step: {quotient bit, new remainder}
   function automatic logic [40:0] div_step(input logic [39:0] rem,
                                            input logic [39:0] dvs,
                                            input logic        inb);
      logic [40:0] t;
      logic [40:0] d;
      logic        q;
      t = {rem, inb};
      d = {1'b0, dvs};
      if (t >= d) begin
         t = t - d;
         q = 1'b1;
      end else begin
         q = 1'b0;
      end
      return {q, t[39:0]};
   endfunction

endpackage

[sv/trigamma_asymptotic_top.sv]
// Trigamma unit: signed Q16.16 argument in, unsigned Q16.16 trigamma out
`timescale 1ns / 1ps

// Computes trigamma(x) for a signed Q16.16 argument. Arguments x >= 6 use the
// asymptotic Bernoulli series; smaller positive arguments evaluate it at x+6
// and add 1/(x+k)^2 for k = 0..5. x <= 0 gives value 0 with arg_valid low; an
// out-of-range value returns all ones with saturated high. The unit takes one
// item every cycle while the result port is not stalled; its depth is set by
// the bit-per-stage restoring dividers (30 stages for 1/x, 48 for the
// correction terms in parallel, 31 for S/x) and the eight-step Horner chain
// between them. A stall at the result port holds the whole pipeline.
module trigamma_asymptotic_top import tga_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_arg_x,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [31:0]        rsp_trigamma_value,
   output logic               rsp_arg_valid,
   output logic               rsp_saturated
);

   item_type         data_ff [NST];
   item_type         data_in [NST];
   logic [NST-1:0]   vld_ff;
   logic             en;

   // whole pipeline advances unless the result is stalled
   assign en        = !vld_ff[NST-1] || rsp_ready;
   assign req_ready = en;

   for (genvar s = 0; s < NST; s++) begin : g_stage
      if (s == ST_IN) begin : g_in
         // capture argument, domain flags and shifted divisors
         always_comb begin
            data_in[s]         = '0;
            data_in[s].bad     = (req_arg_x == 32'sd0) || req_arg_x[31];
            data_in[s].shifted = (req_arg_x[30:0] < SIX_RAW);
            data_in[s].y       = data_in[s].shifted ? req_arg_x[30:0] + SIX_RAW
                                                    : req_arg_x[30:0];
            for (int k = 0; k < LANES; k++) begin
               data_in[s].yk[k] = req_arg_x[19:0] + (20'(k) << 16);
            end
         end
      end else begin : g_work
         localparam int  BIDX = (s >= ST_W + 2 && s < ST_S) ? 7 - (s - ST_W) / 2 : 0;
         localparam int  SBIT = ST_SDIVN - s;
         localparam bit  SUSE = (SBIT >= 16);
         localparam int  SIDX = SUSE ? SBIT - 16 : 0;

         always_comb begin
            logic [40:0]        st;
            logic [59:0]        rr;
            logic [34:0]        mag;
            logic [29:0]        p;
            logic signed [35:0] m;
            logic [33:0]        sv;
            logic               inb;
            logic               anysat;
            st     = '0;
            rr     = '0;
            mag    = '0;
            p      = '0;
            m      = '0;
            sv     = '0;
            inb    = 1'b0;
            anysat = 1'b0;
            data_in[s] = data_ff[s-1];

            // squares of the correction arguments, divider setup
            if (s == ST_SQR) begin
               for (int k = 0; k < LANES; k++) begin
                  data_in[s].dk[k]   = 40'(data_ff[s-1].yk[k]) * 40'(data_ff[s-1].yk[k]);
                  data_in[s].crem[k] = CREM0;
                  data_in[s].cq[k]   = '0;
               end
               data_in[s].rrem = RREM0;
               data_in[s].rq   = '0;
            end

            // a correction term at or above 2^48 saturates on its own
            if (s == ST_DIV0) begin
               for (int k = 0; k < LANES; k++) begin
                  anysat = anysat | (data_ff[s-1].dk[k] <= DSAT_LIM);
               end
               data_in[s].dsat = data_ff[s-1].shifted && anysat;
            end

            // 2^64 / D, one quotient bit per stage in each lane
            if (s >= ST_DIV0 && s <= ST_CDIVN) begin
               for (int k = 0; k < LANES; k++) begin
                  st = div_step(data_ff[s-1].crem[k], data_ff[s-1].dk[k], 1'b0);
                  data_in[s].crem[k] = st[39:0];
                  data_in[s].cq[k]   = {data_ff[s-1].cq[k][46:0], st[40]};
               end
            end

            // r = 2^48 / Y
            if (s >= ST_DIV0 && s <= ST_RDIVN) begin
               st = div_step({9'b0, data_ff[s-1].rrem}, {9'b0, data_ff[s-1].y}, 1'b0);
               data_in[s].rrem = st[30:0];
               data_in[s].rq   = {data_ff[s-1].rq[28:0], st[40]};
            end

            // w = r^2 / 2^32, series starts at B16
            if (s == ST_W) begin
               rr = 60'(data_ff[s-1].rq) * 60'(data_ff[s-1].rq);
               data_in[s].w   = rr[58:32];
               data_in[s].acc = BERN_COEF[7];
            end

            // Horner: odd offset multiplies, even offset adds
            if (s > ST_W && s <= ST_S) begin
               if (((s - ST_W) % 2) == 1) begin
                  data_in[s].neg  = data_ff[s-1].acc[35];
                  mag = data_ff[s-1].acc[35] ? 35'(-data_ff[s-1].acc)
                                             : data_ff[s-1].acc[34:0];
                  data_in[s].prod = 62'(mag) * 62'(data_ff[s-1].w);
               end else begin
                  p = data_ff[s-1].prod[61:32];
                  m = $signed({6'b0, p});
                  if (data_ff[s-1].neg) begin
                     m = -m;
                  end
                  if (s < ST_S) begin
                     data_in[s].acc = BERN_COEF[BIDX] + m;
                  end else begin
                     sv = FX_ONE + m[33:0];
                     data_in[s].su = sv[33] ? 33'd0 : sv[32:0];
                  end
               end
            end

            // S * 2^16 / Y setup
            if (s == ST_SINIT) begin
               data_in[s].srem = 31'(data_ff[s-1].su >> 15);
               data_in[s].sq   = '0;
            end

            if (s >= ST_SDIV0 && s <= ST_SDIVN) begin
               inb = SUSE ? data_ff[s-1].su[SIDX] : 1'b0;
               st  = div_step({9'b0, data_ff[s-1].srem}, {9'b0, data_ff[s-1].y}, inb);
               data_in[s].srem = st[30:0];
               data_in[s].sq   = {data_ff[s-1].sq[29:0], st[40]};
            end

            // correction sum, two levels
            if (s == ST_CSUM0) begin
               for (int j = 0; j < 3; j++) begin
                  data_in[s].c3[j] = 49'(data_ff[s-1].cq[2*j]) +
                                     49'(data_ff[s-1].cq[2*j+1]);
               end
            end
            if (s == ST_CSUM1) begin
               data_in[s].csum = data_ff[s-1].shifted ?
                  51'(data_ff[s-1].c3[0]) + 51'(data_ff[s-1].c3[1]) +
                  51'(data_ff[s-1].c3[2]) : 51'd0;
            end

            // total in Q.32
            if (s == ST_TOT) begin
               data_in[s].total = 52'(data_ff[s-1].w >> 1) + 52'(data_ff[s-1].sq) +
                                  52'(data_ff[s-1].csum);
            end

            // truncate to Q16.16, saturate, zero when out of domain
            if (s == ST_OUT) begin
               if (data_ff[s-1].bad) begin
                  data_in[s].value = '0;
                  data_in[s].sat   = 1'b0;
               end else if (data_ff[s-1].dsat || data_ff[s-1].total[51:48] != 4'd0) begin
                  data_in[s].value = OUT_MAX;
                  data_in[s].sat   = 1'b1;
               end else begin
                  data_in[s].value = data_ff[s-1].total[47:16];
                  data_in[s].sat   = 1'b0;
               end
            end
         end
      end
   end

   // valid bits travel with the items
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NST-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign rsp_valid          = vld_ff[NST-1];
   assign rsp_trigamma_value = data_ff[NST-1].value;
   assign rsp_arg_valid      = !data_ff[NST-1].bad;
   assign rsp_saturated      = data_ff[NST-1].sat;

`include "trigamma_asymptotic_top_assert.svh"

   `TGA_ASSERT_IMP(a_stall_holds_intake, rsp_valid && !rsp_ready, !req_ready, "intake open during stall")
   `TGA_ASSERT_IMP(a_invalid_zero, rsp_valid && !rsp_arg_valid, rsp_trigamma_value == 32'd0 && !rsp_saturated, "domain error item not zeroed")
   `TGA_ASSERT_IMP(a_sat_max, rsp_valid && rsp_saturated, rsp_trigamma_value == OUT_MAX, "saturated item not at maximum")
   `TGA_ASSERT_NXT(a_entry_valid, req_valid && req_ready, vld_ff[0], "accepted item lost at entry")

endmodule
